[src/olir_pkg.sv]
package olir_pkg;

  // field widths fixed by the transaction format
  localparam int KEY_W    = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;

  localparam int CAPACITY_DEFAULT = 16;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam mode_t MODE_APPEND = 2'd0;
  localparam mode_t MODE_FRONT  = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;
  localparam mode_t MODE_CLEAR  = 2'd3;

  // status codes
  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_NOPOS = 2'd2;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             en;
    mode_t            mode;
    logic             ins_ok;
    logic             rem_ok;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } olir_ctl_t;

endpackage

[src/olir_if.sv]
// operation channel
interface olir_op_if;
  import olir_pkg::*;
  logic             valid;
  logic             ready;
  mode_t            mode;
  logic [KEY_W-1:0] key_value;
  logic [POS_W-1:0] position;

  modport source (output valid, output mode, output key_value, output position,
                  input ready);
  modport sink   (input valid, input mode, input key_value, input position,
                  output ready);
endinterface

// result channel
interface olir_res_if;
  import olir_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [COUNT_W-1:0] element_count;
  logic [KEY_W-1:0]   removed_key;
  logic [KEY_W-1:0]   front_key;

  modport source (output valid, output status, output element_count,
                  output removed_key, output front_key, input ready);
  modport sink   (input valid, input status, input element_count,
                  input removed_key, input front_key, output ready);
endinterface

[src/olir_cell.sv]
module olir_cell
  import olir_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic             clk,
  input  olir_ctl_t        ctl,
  input  logic [CW-1:0]    count,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key,
  output logic [KEY_W-1:0] key_next
);

  // cells past the reach of the position field always sit after the hole
  localparam logic             BEYOND_POS = (IDX >= (1 << POS_W));
  localparam logic [POS_W-1:0] IDX_P      = POS_W'(IDX);
  localparam logic [CW-1:0]    IDX_C      = CW'(IDX);

  logic at_or_after;

  assign at_or_after = BEYOND_POS || (IDX_P >= ctl.position);

  // choose own, left or right neighbour, or the new key
  always_comb begin
    key_next = key;
    if (ctl.en) begin
      case (ctl.mode)
        MODE_APPEND: begin
          if (ctl.ins_ok && (count == IDX_C)) key_next = ctl.key;
        end
        MODE_FRONT: begin
          if (ctl.ins_ok) key_next = left_key;
        end
        MODE_REMOVE: begin
          if (ctl.rem_ok && at_or_after) key_next = right_key;
        end
        default: begin
          key_next = key;
        end
      endcase
    end
  end

  // key storage
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

[src/ordered_list_insert_remove_unit.sv]
// Ordered key store, kept as a row of cells with the front at cell 0.
// Channel "op" carries one operation per transaction: append at back,
// insert at front, remove at a position, or clear. Channel "result"
// returns one transaction per operation with status, new element count
// (low five bits), removed key and front key.
// The result is presented in the cycle after the operation is taken.
// Throughput: one operation per cycle unless stalled; every cell loads
// its next key from itself, a neighbour or the new key at the same edge,
// so the row is updated at once and the next operation sees the new order.
// The removed key is selected from the first sixteen cells at most.
// Reset clears the element count and empties the result register; stored
// keys are not cleared, since only cells below the count are ever read.
// When the receiver stalls the result is held, and a new operation is
// taken only in a cycle in which the held result is taken too.
module ordered_list_insert_remove_unit
  import olir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  olir_op_if.sink    op,
  olir_res_if.source result
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PCW   = (CW > POS_W) ? CW : POS_W;
  localparam int EW    = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int SEL_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             full;
  logic             pos_ok;
  logic             accept;
  olir_ctl_t        ctl;
  logic [KEY_W-1:0] cell_key      [CAPACITY];
  logic [KEY_W-1:0] cell_key_next [CAPACITY];
  logic [KEY_W-1:0] selected;
  status_t          status_next;
  logic [KEY_W-1:0] removed_next;
  logic [KEY_W-1:0] front_next;
  logic [EW-1:0]    count_wide;

  logic               res_valid;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic [KEY_W-1:0]   res_removed;
  logic [KEY_W-1:0]   res_front;

  // handshake
  assign op.ready = !res_valid || result.ready;
  assign accept   = op.valid && op.ready;

  // occupancy checks
  assign full   = (count == CW'(CAPACITY));
  assign pos_ok = (PCW'(op.position) < PCW'(count));

  // broadcast to the cells
  always_comb begin
    ctl.en       = accept;
    ctl.mode     = op.mode;
    ctl.ins_ok   = !full;
    ctl.rem_ok   = pos_ok;
    ctl.key      = op.key_value;
    ctl.position = op.position;
  end

  // row of cells, each linked to both neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = op.key_value;
    end else begin : g_mid_left
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_mid_right
      assign right_key = cell_key[i+1];
    end

    olir_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (cell_key[i]),
      .key_next  (cell_key_next[i])
    );
  end

  // key at the requested position
  always_comb begin
    selected = '0;
    for (int j = 0; j < SEL_N; j++) begin
      if (op.position == POS_W'(j)) selected = cell_key[j];
    end
  end

  // count update and result fields
  always_comb begin
    count_next   = count;
    status_next  = STATUS_DONE;
    removed_next = '0;
    case (op.mode)
      MODE_APPEND, MODE_FRONT: begin
        if (full) status_next = STATUS_FULL;
        else count_next = count + CW'(1);
      end
      MODE_REMOVE: begin
        if (!pos_ok) begin
          status_next = STATUS_NOPOS;
        end else begin
          count_next   = count - CW'(1);
          removed_next = selected;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
    front_next = (count_next != '0) ? cell_key_next[0] : '0;
    count_wide = EW'(count_next);
  end

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status  <= status_next;
      res_count   <= count_wide[COUNT_W-1:0];
      res_removed <= removed_next;
      res_front   <= front_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.element_count = res_count;
  assign result.removed_key   = res_removed;
  assign result.front_key     = res_front;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && full && (op.mode == MODE_APPEND || op.mode == MODE_FRONT)
      |=> $stable(count))
    else $error("insert into full store changed the count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (op.mode == MODE_CLEAR) |=> (count == '0))
    else $error("clear left entries behind");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted transaction produced no result");

  a_bad_remove: assert property (@(posedge clk) disable iff (rst)
    accept && (op.mode == MODE_REMOVE) && !pos_ok
      |=> $stable(count) && (res_status == STATUS_NOPOS))
    else $error("remove beyond count altered the store");

endmodule
